// ----- rtl/core/pwsd_pkg.sv -----
// Shared constants, types and the arctangent table for the steering delay block.
package pwsd_pkg;

  localparam int NUM_ELEMENTS = 128;
  localparam int ELEM_W       = 7;
  localparam int ANGLE_W      = 17;
  localparam int SPEED_W      = 12;
  localparam int TICKS_W      = 11;
  localparam logic [SPEED_W-1:0] SPEED_RESET = 12'd1540;

  // CORDIC datapath.
  localparam int CORDIC_STEPS = 18;
  localparam int CXW          = 28;
  localparam int CZW          = 27;
  localparam logic signed [CXW-1:0] CORDIC_X0 = CXW'(2 ** 24);

  // Tangent output, unsigned Q1.16, and its long division.
  localparam int TAN_W   = 17;
  localparam int TQ_W    = TAN_W + 1;
  localparam int TDIV_W  = 44;
  localparam int TDIVR_W = CXW - 1;
  localparam logic [TAN_W-1:0] TAN_MAX = '1;

  // Distance and delay division.
  localparam int POS_W      = 12;
  localparam int UNITS30_W  = 17;
  localparam int DIST_W     = UNITS30_W + TAN_W;
  localparam int DRW        = 42;
  localparam int DQ_W       = TICKS_W + 1;
  localparam logic [POS_W-1:0] FAR_END = POS_W'((NUM_ELEMENTS - 1) * 10 + 5);
  localparam logic [TICKS_W-1:0] TICKS_MAX = '1;

  // Cycles from the start beat to the done strobe.
  localparam int TAN_LATENCY   = CORDIC_STEPS + 1 + TQ_W + 1;
  localparam int DELAY_LATENCY = 3 + DQ_W + 1;
  localparam int LATENCY       = TAN_LATENCY + DELAY_LATENCY;

  typedef struct packed {
    logic [ELEM_W-1:0] elem;
    logic              neg;
  } pwsd_tag_t;

  typedef enum logic [1:0] {
    TAN_NORM,
    TAN_ZERO,
    TAN_SAT
  } tan_code_t;

  // arctan(2^-i) in units of 1/256 millidegree.
  function automatic logic signed [CZW-1:0] atan_lut(input int i);
    logic signed [CZW-1:0] v;
    case (i)
      0:       v = CZW'(11520000);
      1:       v = CZW'(6800653);
      2:       v = CZW'(3593278);
      3:       v = CZW'(1824004);
      4:       v = CZW'(915542);
      5:       v = CZW'(458217);
      6:       v = CZW'(229164);
      7:       v = CZW'(114589);
      8:       v = CZW'(57295);
      9:       v = CZW'(28648);
      10:      v = CZW'(14324);
      11:      v = CZW'(7162);
      12:      v = CZW'(3581);
      13:      v = CZW'(1790);
      14:      v = CZW'(895);
      15:      v = CZW'(448);
      16:      v = CZW'(224);
      17:      v = CZW'(112);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/plane_wave_steering_delay.sv -----
// Top level of the plane-wave transmit steering delay block.
// The block takes one query (steering angle, element index) on every cycle that start is
// high; busy never rises, so a full delay table streams in at one element per clock. Each
// result appears in order, for a single cycle with done high, and the receiver cannot
// stall it. The path runs through the 18 CORDIC rotation stages, the 18-stage tangent
// divide and the 12-stage delay divide. Write speed_of_sound only while no query is in
// flight; cfg_ready is always high.
module plane_wave_steering_delay
  import pwsd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [ANGLE_W-1:0] angle_millideg,
  input  logic [ELEM_W-1:0]         element_index,
  output logic                      done,
  output logic [ELEM_W-1:0]         element_out,
  output logic [TICKS_W-1:0]        delay_ticks,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [SPEED_W-1:0]        cfg_data
);

  logic [SPEED_W-1:0] speed_of_sound;
  logic               accept;
  logic [TAN_W-1:0]   mag;
  pwsd_tag_t          tag;
  logic               tan_valid;
  logic [TAN_W-1:0]   tan_q16;
  pwsd_tag_t          tan_tag;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_of_sound <= SPEED_RESET;
    end else if (cfg_valid && cfg_ready) begin
      speed_of_sound <= cfg_data;
    end
  end

  // Magnitude of the angle; the most negative code maps to 65536.
  assign mag      = angle_millideg[ANGLE_W-1] ? (~angle_millideg + 1'b1) : angle_millideg;
  assign tag.elem = element_index;
  assign tag.neg  = angle_millideg[ANGLE_W-1];

  pwsd_tan u_tan (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .mag       (mag),
    .in_tag    (tag),
    .out_valid (tan_valid),
    .tan_q16   (tan_q16),
    .out_tag   (tan_tag)
  );

  pwsd_delay u_delay (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (tan_valid),
    .tan_q16     (tan_q16),
    .in_tag      (tan_tag),
    .speed       (speed_of_sound),
    .done        (done),
    .element_out (element_out),
    .delay_ticks (delay_ticks)
  );

endmodule

// ----- rtl/core/pwsd_tan.sv -----
// Pipelined CORDIC rotation followed by a pipelined restoring divide giving tan in Q1.16.
module pwsd_tan
  import pwsd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [TAN_W-1:0] mag,
  input  pwsd_tag_t        in_tag,
  output logic             out_valid,
  output logic [TAN_W-1:0] tan_q16,
  output pwsd_tag_t        out_tag
);

  logic                  cv [1:CORDIC_STEPS];
  logic signed [CXW-1:0] cx [1:CORDIC_STEPS];
  logic signed [CXW-1:0] cy [1:CORDIC_STEPS];
  logic signed [CZW-1:0] cz [1:CORDIC_STEPS];
  pwsd_tag_t             ct [1:CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    localparam logic signed [CZW-1:0] ATAN = atan_lut(i);
    logic                  vi;
    logic signed [CXW-1:0] xi;
    logic signed [CXW-1:0] yi;
    logic signed [CZW-1:0] zi;
    pwsd_tag_t             ti;

    if (i == 0) begin : g_first
      assign vi = in_valid;
      assign xi = CORDIC_X0;
      assign yi = '0;
      assign zi = {2'b00, mag, 8'h00};
      assign ti = in_tag;
    end else begin : g_next
      assign vi = cv[i];
      assign xi = cx[i];
      assign yi = cy[i];
      assign zi = cz[i];
      assign ti = ct[i];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else begin
        cv[i+1] <= vi;
      end
      if (!zi[CZW-1]) begin
        cx[i+1] <= xi - (yi >>> i);
        cy[i+1] <= yi + (xi >>> i);
        cz[i+1] <= zi - ATAN;
      end else begin
        cx[i+1] <= xi + (yi >>> i);
        cy[i+1] <= yi - (xi >>> i);
        cz[i+1] <= zi + ATAN;
      end
      ct[i+1] <= ti;
    end
  end

  // Set up the divide: numerator y*65536 + x/2 over divisor x.
  logic                dv;
  logic [TDIV_W-1:0]   dn;
  logic [TDIVR_W-1:0]  dd;
  tan_code_t           dc;
  pwsd_tag_t           dt;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= 1'b0;
    end else begin
      dv <= cv[CORDIC_STEPS];
    end
    dn <= TDIV_W'({cy[CORDIC_STEPS][CXW-2:0], 16'h0000})
        + TDIV_W'(cx[CORDIC_STEPS][CXW-2:1]);
    dd <= cx[CORDIC_STEPS][CXW-2:0];
    if (cy[CORDIC_STEPS][CXW-1]) begin
      dc <= TAN_ZERO;
    end else if (cx[CORDIC_STEPS][CXW-1] || cx[CORDIC_STEPS] == '0) begin
      dc <= TAN_SAT;
    end else begin
      dc <= TAN_NORM;
    end
    dt <= ct[CORDIC_STEPS];
  end

  // One quotient bit per stage, top bit first; a set top bit means overflow.
  logic               qv [1:TQ_W];
  logic [TDIV_W-1:0]  qr [1:TQ_W];
  logic [TQ_W-1:0]    qq [1:TQ_W];
  logic [TDIVR_W-1:0] qd [1:TQ_W];
  tan_code_t          qc [1:TQ_W];
  pwsd_tag_t          qt [1:TQ_W];

  for (genvar k = 0; k < TQ_W; k++) begin : g_div
    localparam int B = TQ_W - 1 - k;
    logic               vi;
    logic [TDIV_W-1:0]  ri;
    logic [TQ_W-1:0]    qi;
    logic [TDIVR_W-1:0] di;
    tan_code_t          ci;
    pwsd_tag_t          ti;
    logic [TDIV_W-1:0]  sub;

    if (k == 0) begin : g_first
      assign vi = dv;
      assign ri = dn;
      assign qi = '0;
      assign di = dd;
      assign ci = dc;
      assign ti = dt;
    end else begin : g_next
      assign vi = qv[k];
      assign ri = qr[k];
      assign qi = qq[k];
      assign di = qd[k];
      assign ci = qc[k];
      assign ti = qt[k];
    end

    assign sub = TDIV_W'(di) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        qv[k+1] <= 1'b0;
      end else begin
        qv[k+1] <= vi;
      end
      if (ri >= sub) begin
        qr[k+1] <= ri - sub;
        qq[k+1] <= {qi[TQ_W-2:0], 1'b1};
      end else begin
        qr[k+1] <= ri;
        qq[k+1] <= {qi[TQ_W-2:0], 1'b0};
      end
      qd[k+1] <= di;
      qc[k+1] <= ci;
      qt[k+1] <= ti;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= qv[TQ_W];
    end
    case (qc[TQ_W])
      TAN_NORM: tan_q16 <= qq[TQ_W][TQ_W-1] ? TAN_MAX : qq[TQ_W][TAN_W-1:0];
      TAN_ZERO: tan_q16 <= '0;
      TAN_SAT:  tan_q16 <= TAN_MAX;
      default:  tan_q16 <= '0;
    endcase
    out_tag <= qt[TQ_W];
  end

endmodule

// ----- rtl/core/pwsd_delay.sv -----
// Distance product and pipelined rounding divide by the speed of sound, in 25 ns ticks.
module pwsd_delay
  import pwsd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [TAN_W-1:0]   tan_q16,
  input  pwsd_tag_t          in_tag,
  input  logic [SPEED_W-1:0] speed,
  output logic               done,
  output logic [ELEM_W-1:0]  element_out,
  output logic [TICKS_W-1:0] delay_ticks
);

  logic [POS_W-1:0] pos;
  assign pos = POS_W'(in_tag.elem) * POS_W'(10) + POS_W'(5);

  // Stage A: distance in array units times 30 microns.
  logic                 av;
  logic [UNITS30_W-1:0] a_u30;
  logic                 a_neg_dist;
  logic [TAN_W-1:0]     a_tan;
  logic [ELEM_W-1:0]    a_elem;

  always_ff @(posedge clk) begin
    if (rst) begin
      av <= 1'b0;
    end else begin
      av <= in_valid;
    end
    a_neg_dist <= !in_tag.neg && (pos > FAR_END);
    if (in_tag.neg) begin
      a_u30 <= UNITS30_W'(pos) * UNITS30_W'(30);
    end else begin
      a_u30 <= UNITS30_W'(FAR_END - pos) * UNITS30_W'(30);
    end
    a_tan  <= tan_q16;
    a_elem <= in_tag.elem;
  end

  // Stage B: the one real multiply.
  logic              bv;
  logic [DIST_W-1:0] b_d;
  logic              b_neg_dist;
  logic [ELEM_W-1:0] b_elem;

  always_ff @(posedge clk) begin
    if (rst) begin
      bv <= 1'b0;
    end else begin
      bv <= av;
    end
    b_d        <= DIST_W'(a_u30) * DIST_W'(a_tan);
    b_neg_dist <= a_neg_dist;
    b_elem     <= a_elem;
  end

  // Stage C: numerator d*40 + c*32768 over divisor c*65536.
  logic               cv;
  logic [DRW-1:0]     c_n;
  logic [SPEED_W-1:0] c_c;
  logic               c_neg_dist;
  logic [ELEM_W-1:0]  c_elem;

  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= 1'b0;
    end else begin
      cv <= bv;
    end
    c_n <= (DRW'(b_d) << 5) + (DRW'(b_d) << 3) + (DRW'(speed) << 15);
    c_c        <= speed;
    c_neg_dist <= b_neg_dist;
    c_elem     <= b_elem;
  end

  // One quotient bit per stage; the top bit flags saturation, and a zero
  // speed sets every bit so it saturates as well.
  logic               sv [1:DQ_W];
  logic [DRW-1:0]     sr [1:DQ_W];
  logic [DQ_W-1:0]    sq [1:DQ_W];
  logic [SPEED_W-1:0] sc [1:DQ_W];
  logic               sz [1:DQ_W];
  logic [ELEM_W-1:0]  se [1:DQ_W];

  for (genvar k = 0; k < DQ_W; k++) begin : g_div
    localparam int B = DQ_W - 1 - k;
    logic               vi;
    logic [DRW-1:0]     ri;
    logic [DQ_W-1:0]    qi;
    logic [SPEED_W-1:0] ci;
    logic               zi;
    logic [ELEM_W-1:0]  ei;
    logic [DRW-1:0]     sub;

    if (k == 0) begin : g_first
      assign vi = cv;
      assign ri = c_n;
      assign qi = '0;
      assign ci = c_c;
      assign zi = c_neg_dist;
      assign ei = c_elem;
    end else begin : g_next
      assign vi = sv[k];
      assign ri = sr[k];
      assign qi = sq[k];
      assign ci = sc[k];
      assign zi = sz[k];
      assign ei = se[k];
    end

    assign sub = DRW'(ci) << (16 + B);

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else begin
        sv[k+1] <= vi;
      end
      if (ri >= sub) begin
        sr[k+1] <= ri - sub;
        sq[k+1] <= {qi[DQ_W-2:0], 1'b1};
      end else begin
        sr[k+1] <= ri;
        sq[k+1] <= {qi[DQ_W-2:0], 1'b0};
      end
      sc[k+1] <= ci;
      sz[k+1] <= zi;
      se[k+1] <= ei;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sv[DQ_W];
    end
    if (sz[DQ_W]) begin
      delay_ticks <= '0;
    end else if (sq[DQ_W][DQ_W-1]) begin
      delay_ticks <= TICKS_MAX;
    end else begin
      delay_ticks <= sq[DQ_W][TICKS_W-1:0];
    end
    element_out <= se[DQ_W];
  end

endmodule

// ----- rtl/core/pwsd_checker.sv -----
// Port-level checker for the steering delay block, bound to the top level.
module pwsd_checker
  import pwsd_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic [ELEM_W-1:0] element_index,
  input logic              done,
  input logic [ELEM_W-1:0] element_out,
  input logic              cfg_ready
);

  // Every result traces back to a start beat exactly one latency earlier.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("done without a matching start beat");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("start beat produced no result");

  a_elem_echo: assert property (@(posedge clk) disable iff (rst)
    done |-> element_out == $past(element_index, LATENCY))
    else $error("element_out does not match its query");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("done right after reset");

  a_always_ready: assert property (@(posedge clk) disable iff (rst)
    !busy && cfg_ready)
    else $error("block refused a beat");

endmodule

bind plane_wave_steering_delay pwsd_checker u_pwsd_checker (.*);
